// ===== src/bnht_pkg.sv =====
package bnht_pkg;

    localparam int MAX_NODES_DEF = 8;
    localparam logic [31:0] DISCOVERY_PERIOD_MS_DEF = 32'd30000;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_OVERV = 2'd2;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_IGNORE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_DISABLE = 2'd3;

    localparam logic [2:0] ST_UNKNOWN     = 3'd0;
    localparam logic [2:0] ST_DISCOVERING = 3'd1;
    localparam logic [2:0] ST_ONLINE      = 3'd2;
    localparam logic [2:0] ST_WARNING     = 3'd4;
    localparam logic [2:0] ST_OFFLINE     = 3'd5;

    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_BASE    = 3'd1;
    localparam logic [2:0] REG_ID_MIN  = 3'd2;
    localparam logic [2:0] REG_ID_MAX  = 3'd3;
    localparam logic [2:0] REG_WARN    = 3'd4;
    localparam logic [2:0] REG_OFFLINE = 3'd5;
    localparam logic [2:0] REG_LEGACY  = 3'd6;

    // Entry word: node id, state, link ok, charge enabled, last seen, count.
    localparam int ENTRY_W = 16 + 3 + 1 + 1 + 32 + 32;

    typedef struct packed {
        logic [15:0] node_id;
        logic [2:0]  st;
        logic        link_ok;
        logic        charge_en;
        logic [31:0] last_seen;
        logic [31:0] msg_count;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_SUMMARY,
        S_OUT
    } state_t;

endpackage

// ===== src/bnht_ram.sv =====
module bnht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/bus_node_health_tracker.sv =====
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/ready  | opcode, can_identifier, data_length, now_ms
// out     | output    | out_valid/ready | kind, node_id, entry_index, node_state,
//         |           |                 | table_full, online_nodes, discovery_due,
//         |           |                 | timeout_total, last
// cfg     | input     | cfg_we          | cfg_index, cfg_data
//
// One item at a time. The node table is a single RAM with a registered read; an
// item walks it entry by entry (read, then modify and write back), a frame up
// to its match and a bad frame not at all. Reset clears the control state, the
// fill count, counters and configuration, not the table or the held item and
// result-beat registers. A result beat that is not taken holds the walk in place.
module bus_node_health_tracker
#(
    parameter int MAX_NODES = bnht_pkg::MAX_NODES_DEF,
    parameter logic [31:0] DISCOVERY_PERIOD_MS = bnht_pkg::DISCOVERY_PERIOD_MS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [28:0] can_identifier,
    input  logic [3:0]  data_length,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] node_id,
    output logic [2:0]  entry_index,
    output logic [2:0]  node_state,
    output logic        table_full,
    output logic [3:0]  online_nodes,
    output logic        discovery_due,
    output logic [31:0] timeout_total,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bnht_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    // configuration
    logic        enable_reg;
    logic [4:0]  base_reg;
    logic [15:0] id_min_reg, id_max_reg, legacy_reg;
    logic [31:0] warn_reg, offl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            base_reg   <= '0;
            id_min_reg <= '0;
            id_max_reg <= 16'hFFFF;
            warn_reg   <= 32'd5000;
            offl_reg   <= 32'd15000;
            legacy_reg <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:  enable_reg <= cfg_data[0];
                REG_BASE:    base_reg   <= cfg_data[4:0];
                REG_ID_MIN:  id_min_reg <= cfg_data[15:0];
                REG_ID_MAX:  id_max_reg <= cfg_data[15:0];
                REG_WARN:    warn_reg   <= cfg_data;
                REG_OFFLINE: offl_reg   <= cfg_data;
                REG_LEGACY:  legacy_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control state
    state_t      state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0] tcnt_reg, tcnt_next;
    logic [31:0] ldisc_reg, ldisc_next;
    logic [3:0]  online_reg, online_next;
    logic        due_reg, due_next;
    logic        found_reg, found_next;
    logic [CW-1:0] fidx_reg, fidx_next;
    logic [3:0]  ncmd_reg, ncmd_next;
    // held disable command, sent once the walk shows whether another follows
    logic        hold_reg, hold_next;
    logic [15:0] hnid_reg, hnid_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [2:0]  hst_reg, hst_next;
    // held item
    logic [1:0]  op_reg;
    logic [28:0] id_reg;
    logic [3:0]  dlc_reg;
    logic [31:0] now_reg;
    logic [31:0] legacy_ms_reg;
    // result beat
    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] nid_reg, nid_next;
    logic [2:0]  eidx_reg, eidx_next;
    logic [2:0]  nst_reg, nst_next;
    logic        full_reg, full_next;
    logic [3:0]  oc_reg, oc_next;
    logic        od_reg, od_next;
    logic        last_reg, last_next;

    // RAM
    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    bnht_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic accept;
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign accept   = in_valid && in_ready;

    logic [15:0] src;
    logic        frame_bad;
    assign src = id_reg[15:0];
    assign frame_bad = (dlc_reg > 4'd8) || (id_reg[28:24] != base_reg) ||
                       (src < id_min_reg) || (src > id_max_reg);

    // entry that takes a disable command
    logic cand;
    assign cand = rdata.link_ok && rdata.charge_en && (ncmd_reg < 4'd8);

    // entry advance on an entry word
    function automatic entry_t advance(entry_t e, logic [31:0] now, logic [31:0] w,
                                       logic [31:0] o, output logic tmo);
        logic [31:0] el;
        entry_t r;
        el  = now - e.last_seen;
        r   = e;
        tmo = 1'b0;
        case (e.st)
            ST_UNKNOWN, ST_DISCOVERING:
            begin
                if (e.msg_count != 0)
                begin
                    r.st = ST_ONLINE; r.link_ok = 1'b1;
                end
            end
            ST_ONLINE:
            begin
                if (el > o)
                begin
                    r.st = ST_OFFLINE; r.link_ok = 1'b0; tmo = 1'b1;
                end
                else if (el > w)
                begin
                    r.st = ST_WARNING; r.link_ok = 1'b0;
                end
            end
            ST_WARNING:
            begin
                if (el > o)
                begin
                    r.st = ST_OFFLINE; r.link_ok = 1'b0; tmo = 1'b1;
                end
                else if (el < w)
                begin
                    r.st = ST_ONLINE; r.link_ok = 1'b1;
                end
            end
            ST_OFFLINE:
            begin
                if (el < w)
                begin
                    r.st = ST_ONLINE; r.link_ok = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    entry_t e_frame, e_tick, e_pre;
    logic   t_frame, t_tick, t_leg;

    always_comb
    begin
        // frame update of a found entry
        e_pre = rdata;
        e_pre.last_seen = now_reg;
        e_pre.link_ok   = 1'b1;
        e_pre.msg_count = rdata.msg_count + 32'd1;
        e_frame = advance(e_pre, now_reg, warn_reg, offl_reg, t_frame);
        // tick: legacy timeout then advance
        e_pre = rdata;
        t_leg = rdata.link_ok && ((now_reg - rdata.last_seen) > legacy_ms_reg);
        if (t_leg)
        begin
            e_pre.link_ok = 1'b0;
        end
        e_tick = advance(e_pre, now_reg, warn_reg, offl_reg, t_tick);
    end

    logic at_end;
    assign at_end = (idx_reg >= used_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && enable_reg &&
                    (opcode == OP_FRAME || opcode == OP_TICK || opcode == OP_OVERV))
                begin
                    state_next = S_READ;
                end
            S_READ:
                state_next = S_PROC;
            S_PROC:
            begin
                if (op_reg == OP_FRAME)
                begin
                    if (frame_bad || at_end || found_reg)
                        state_next = S_OUT;
                    else if (rdata.node_id == src)
                        state_next = S_OUT;
                    else
                        state_next = S_READ;
                end
                else if (at_end)
                begin
                    if (op_reg == OP_TICK)
                        state_next = S_SUMMARY;
                    else
                        state_next = hold_reg ? S_OUT : S_IDLE;
                end
                else if (op_reg == OP_OVERV && cand && hold_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SUMMARY:
                state_next = S_OUT;
            S_OUT:
                if (!ov_reg || out_ready)
                begin
                    state_next = (op_reg == OP_OVERV && !last_reg) ? S_READ : S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        used_next  = used_reg;
        idx_next   = idx_reg;
        tcnt_next  = tcnt_reg;
        ldisc_next = ldisc_reg;
        online_next = online_reg;
        due_next   = due_reg;
        found_next = found_reg;
        fidx_next  = fidx_reg;
        ncmd_next  = ncmd_reg;
        hold_next  = hold_reg;
        hnid_next  = hnid_reg;
        hidx_next  = hidx_reg;
        hst_next   = hst_reg;
        ov_next    = ov_reg && !out_ready;
        kind_next  = kind_reg;
        nid_next   = nid_reg;
        eidx_next  = eidx_reg;
        nst_next   = nst_reg;
        full_next  = full_reg;
        oc_next    = oc_reg;
        od_next    = od_reg;
        last_next  = last_reg;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                idx_next    = '0;
                online_next = '0;
                found_next  = 1'b0;
                ncmd_next   = '0;
                due_next    = 1'b0;
                hold_next   = 1'b0;
            end
            S_READ: ;
            S_PROC:
            begin
                if (op_reg == OP_FRAME)
                begin
                    if (!frame_bad && !at_end && rdata.node_id == src)
                    begin
                        we = 1'b1;
                        wdata = e_frame;
                        tcnt_next = tcnt_reg + {31'd0, t_frame};
                        found_next = 1'b1;
                        fidx_next = idx_reg;
                        nst_next = e_frame.st;
                    end
                    else if (!frame_bad && !at_end)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else if (!at_end)
                begin
                    if (op_reg == OP_TICK)
                    begin
                        we = 1'b1;
                        wdata = e_tick;
                        tcnt_next = tcnt_reg + {31'd0, t_leg} + {31'd0, t_tick};
                        if (e_tick.st == ST_ONLINE && online_reg != 4'd15)
                            online_next = online_reg + 4'd1;
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        // clear charging and hold the command for later
                        if (cand)
                        begin
                            we = 1'b1;
                            wdata = rdata;
                            wdata.charge_en = 1'b0;
                            hold_next = 1'b1;
                            hnid_next = rdata.node_id;
                            hidx_next = 3'(idx_reg);
                            hst_next  = rdata.st;
                            ncmd_next = ncmd_reg + 4'd1;
                        end
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_SUMMARY: ;
            S_OUT: ;
            default: ;
        endcase

        // frame registration path: a new node lands online with a count of one
        if (state_reg == S_PROC && op_reg == OP_FRAME && !frame_bad && at_end &&
            !found_reg && used_reg < CW'(MAX_NODES))
        begin
            we = 1'b1;
            waddr = used_reg[AW-1:0];
            wdata.node_id   = src;
            wdata.link_ok   = 1'b1;
            wdata.charge_en = 1'b1;
            wdata.last_seen = now_reg;
            wdata.msg_count = 32'd1;
            wdata.st        = ST_ONLINE;
            used_next = used_reg + CW'(1);
            found_next = 1'b1;
            fidx_next = used_reg;
            nst_next = ST_ONLINE;
        end

        // emit beats when entering S_OUT
        if (state_next == S_OUT && state_reg != S_OUT)
        begin
            ov_next   = 1'b1;
            full_next = 1'b0;
            oc_next   = '0;
            od_next   = 1'b0;
            last_next = 1'b1;
            if (op_reg == OP_FRAME)
            begin
                if (frame_bad)
                begin
                    kind_next = KIND_IGNORE; nid_next = '0; eidx_next = '0; nst_next = '0;
                end
                else if (found_next)
                begin
                    kind_next = KIND_ACCEPT; nid_next = src; eidx_next = 3'(fidx_next);
                end
                else
                begin
                    kind_next = KIND_IGNORE; nid_next = src; eidx_next = '0;
                    nst_next = '0; full_next = 1'b1;
                end
            end
            else if (op_reg == OP_TICK)
            begin
                kind_next = KIND_TICK; nid_next = '0; eidx_next = '0; nst_next = '0;
                oc_next = online_reg; od_next = due_reg;
            end
            else
            begin
                // send the held command; it is the final one once the walk ends
                kind_next = KIND_DISABLE;
                nid_next  = hnid_reg;
                eidx_next = hidx_reg;
                nst_next  = hst_reg;
                last_next = at_end;
                if (at_end)
                    hold_next = 1'b0;
            end
        end
        if (state_reg == S_READ && op_reg == OP_TICK && idx_reg == '0 && !due_reg &&
            (now_reg - ldisc_reg) >= DISCOVERY_PERIOD_MS)
        begin
            due_next = 1'b1;
            ldisc_next = now_reg;
        end
    end

    // Command beats are held until the walk shows whether another follows;
    // a candidate found while one is held flushes it first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            idx_reg    <= '0;
            tcnt_reg   <= '0;
            ldisc_reg  <= '0;
            online_reg <= '0;
            due_reg    <= 1'b0;
            found_reg  <= 1'b0;
            fidx_reg   <= '0;
            ncmd_reg   <= '0;
            hold_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            idx_reg    <= idx_next;
            tcnt_reg   <= tcnt_next;
            ldisc_reg  <= ldisc_next;
            online_reg <= online_next;
            due_reg    <= due_next;
            found_reg  <= found_next;
            fidx_reg   <= fidx_next;
            ncmd_reg   <= ncmd_next;
            hold_reg   <= hold_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            id_reg  <= can_identifier;
            dlc_reg <= data_length;
            now_reg <= now_ms;
            legacy_ms_reg <= 32'(legacy_reg) * 32'd1000;
        end
        hnid_reg <= hnid_next;
        hidx_reg <= hidx_next;
        hst_reg  <= hst_next;
        kind_reg <= kind_next;
        nid_reg  <= nid_next;
        eidx_reg <= eidx_next;
        nst_reg  <= nst_next;
        full_reg <= full_next;
        oc_reg   <= oc_next;
        od_reg   <= od_next;
        last_reg <= last_next;
    end

    assign out_valid     = ov_reg;
    assign kind          = kind_reg;
    assign node_id       = nid_reg;
    assign entry_index   = eidx_reg;
    assign node_state    = nst_reg;
    assign table_full    = full_reg;
    assign online_nodes  = oc_reg;
    assign discovery_due = od_reg;
    assign timeout_total = tcnt_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_NODES)) else $error("fill count past depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> ($past(op_reg) == OP_FRAME))
        else $error("fill count moved outside a frame");
`endif
endmodule
